@@ rtl/lmrs_pkg.sv @@
// Shared types and constants for the LED matrix rainbow sparkle frame renderer.
// Holds the frame geometry, register codes, reset values and the colour types.
// No dependencies.
package lmrs_pkg;

  // The pixel count must be a power of two, so index arithmetic wraps by width.
  localparam int unsigned PIX_CNT     = 256;
  localparam int unsigned ROW_LEN     = 16;
  localparam int unsigned PIX_W       = $clog2(PIX_CNT);
  localparam int unsigned RISE_STRIDE = ROW_LEN + 1;
  localparam int unsigned FALL_STRIDE = ROW_LEN - 1;

  localparam int unsigned LVL_W      = 8;
  localparam int unsigned SUM_W      = LVL_W + 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 3 * LVL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY = 2'd0,
    REG_PEAK  = 2'd1,
    REG_FLOOR = 2'd2,
    REG_SHIFT = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_RENDER = 1'b1
  } func_e;

  localparam logic [LVL_W-1:0] DECAY_RST = 8'd30;
  localparam logic [LVL_W-1:0] PEAK_RST  = 8'd255;
  localparam logic [LVL_W-1:0] FLOOR_RST = 8'd0;
  localparam logic [LVL_W-1:0] SHIFT_RST = 8'd96;

  typedef struct packed {
    logic [LVL_W-1:0] fade_step;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] floor_level;
    logic [LVL_W-1:0] base_shift;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] blue;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } rgb_sum_t;

  typedef struct packed {
    logic sum_en;
    logic out_en;
  } mrg_ctl_t;

endpackage

@@ rtl/led_matrix_rainbow_sparkle_frame_top.sv @@
// LED matrix frame renderer with a rotating base colour table and two sparkle layers.
// Holds the input stage, the base and sparkle memories, the decay stage and the merge.
// Depends on lmrs_pkg and lmrs_merge.

// The block takes one beat per cycle unless the output stalls, and gives one pixel beat for
// each render beat; load beats produce nothing. The pipeline has five register stages:
// input capture, memory read, sparkle decay and layer write, colour sum, and clamp into
// the output register. Each stage moves on when the next one is free, so bubbles close up
// and a stalled output holds back only the stages behind it. The sparkle memories need
// no clearing after reset: the previous frame buffer reads as zero until the first frame
// has been rendered, and the block accepts beats right after reset.
module led_matrix_rainbow_sparkle_frame_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // base_red, base_green, base_blue, spark_rise, spark_fall, zero fill
  input  logic [lmrs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red, green, blue
  output logic [lmrs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [lmrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lmrs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lmrs_pkg::*;

  localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIX_CNT - 1);
  localparam logic [PIX_W-1:0] RISE_OFS = PIX_W'(RISE_STRIDE);
  localparam logic [PIX_W-1:0] FALL_OFS = PIX_W'(FALL_STRIDE);

  cfg_t cfg_q;

  logic [PIX_W-1:0] pix_cnt_q;
  logic [PIX_W-1:0] load_ptr_q;
  logic [PIX_W-1:0] rot_off_q;
  logic [PIX_W-1:0] rot_off_d;
  logic             buf_sel_q;
  logic             prev_ok_q;

  logic en1, en2, en3, en4, en_o;
  logic acc;
  logic acc_render;

  // Stage 1
  logic             v1_q;
  func_e            func1_q;
  rgb_t             col1_q;
  logic             rise_trig1_q, fall_trig1_q;
  logic [PIX_W-1:0] idx1_q, off1_q, ldp1_q;
  logic             buf1_q, prev_ok1_q, last1_q;

  // Stage 2
  logic             v2_q;
  rgb_t             base2_q;
  logic [LVL_W-1:0] rise_rd2_q, fall_rd2_q;
  logic             rise_ok2_q, fall_ok2_q;
  logic             rise_trig2_q, fall_trig2_q;
  logic [PIX_W-1:0] idx2_q;
  logic             buf2_q, last2_q;

  // Stage 3
  logic             v3_q;
  rgb_t             base3_q;
  logic [LVL_W-1:0] rise3_q, fall3_q;
  logic             last3_q;
  logic [LVL_W-1:0] rise_nxt, fall_nxt;

  // Stage 4 and output
  logic             v4_q, last4_q;
  logic             vo_q, lasto_q;
  mrg_ctl_t         mrg_ctl;
  rgb_t             pix;

  logic [PIX_W-1:0] src1;
  logic [PIX_W-1:0] shift_m;

  rgb_t             base_mem [PIX_CNT];
  logic [LVL_W-1:0] rise_mem [2*PIX_CNT];
  logic [LVL_W-1:0] fall_mem [2*PIX_CNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fade_step   <= DECAY_RST;
      cfg_q.peak_level  <= PEAK_RST;
      cfg_q.floor_level <= FLOOR_RST;
      cfg_q.base_shift  <= SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DECAY: cfg_q.fade_step   <= cfg_data_i;
        REG_PEAK:  cfg_q.peak_level  <= cfg_data_i;
        REG_FLOOR: cfg_q.floor_level <= cfg_data_i;
        REG_SHIFT: cfg_q.base_shift  <= cfg_data_i;
        default:   cfg_q <= cfg_q;
      endcase
    end
  end

  assign en_o = !vo_q || m_axis_tready;
  assign en4  = !v4_q || en_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign s_axis_tready = en1;
  assign acc           = s_axis_tvalid && en1;
  assign acc_render    = acc && (func_e'(s_axis_tuser) == FUNC_RENDER);

  assign shift_m   = PIX_W'(cfg_q.base_shift % PIX_CNT);
  assign rot_off_d = (pix_cnt_q == '0) ? rot_off_q + shift_m : rot_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q  <= '0;
      load_ptr_q <= '0;
      rot_off_q  <= '0;
      buf_sel_q  <= 1'b0;
      prev_ok_q  <= 1'b0;
    end else if (acc) begin
      if (acc_render) begin
        rot_off_q <= rot_off_d;
        if (pix_cnt_q == PIX_LAST) begin
          pix_cnt_q <= '0;
          buf_sel_q <= !buf_sel_q;
          prev_ok_q <= 1'b1;
        end else begin
          pix_cnt_q <= pix_cnt_q + 1'b1;
        end
      end else begin
        load_ptr_q <= load_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q && (func1_q == FUNC_RENDER);
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en_o) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      func1_q      <= func_e'(s_axis_tuser);
      col1_q.red   <= s_axis_tdata[7:0];
      col1_q.green <= s_axis_tdata[15:8];
      col1_q.blue  <= s_axis_tdata[23:16];
      rise_trig1_q <= s_axis_tdata[24];
      fall_trig1_q <= s_axis_tdata[25];
      idx1_q       <= pix_cnt_q;
      off1_q       <= rot_off_d;
      ldp1_q       <= load_ptr_q;
      buf1_q       <= buf_sel_q;
      prev_ok1_q   <= prev_ok_q;
      last1_q      <= (pix_cnt_q == PIX_LAST);
    end
  end

  assign src1 = idx1_q - off1_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q && (func1_q == FUNC_LOAD)) begin
      base_mem[ldp1_q] <= col1_q;
    end
    if (en2) begin
      base2_q <= base_mem[src1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      rise_mem[{buf2_q, idx2_q}] <= rise_nxt;
    end
    if (en2) begin
      rise_rd2_q <= rise_mem[{!buf1_q, idx1_q - RISE_OFS}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      fall_mem[{buf2_q, idx2_q}] <= fall_nxt;
    end
    if (en2) begin
      fall_rd2_q <= fall_mem[{!buf1_q, idx1_q - FALL_OFS}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      rise_ok2_q   <= prev_ok1_q && (idx1_q >= RISE_OFS);
      fall_ok2_q   <= prev_ok1_q && (idx1_q >= FALL_OFS);
      rise_trig2_q <= rise_trig1_q;
      fall_trig2_q <= fall_trig1_q;
      idx2_q       <= idx1_q;
      buf2_q       <= buf1_q;
      last2_q      <= last1_q;
    end
  end

  always_comb begin
    if (rise_trig2_q) begin
      rise_nxt = cfg_q.peak_level;
    end else if (rise_ok2_q && (rise_rd2_q > cfg_q.fade_step)) begin
      rise_nxt = rise_rd2_q - cfg_q.fade_step;
    end else begin
      rise_nxt = '0;
    end
    if (fall_trig2_q) begin
      fall_nxt = cfg_q.peak_level;
    end else if (fall_ok2_q && (fall_rd2_q > cfg_q.fade_step)) begin
      fall_nxt = fall_rd2_q - cfg_q.fade_step;
    end else begin
      fall_nxt = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      base3_q <= base2_q;
      rise3_q <= rise_nxt;
      fall3_q <= fall_nxt;
      last3_q <= last2_q;
    end
    if (en4) begin
      last4_q <= last3_q;
    end
    if (en_o) begin
      lasto_q <= last4_q;
    end
  end

  assign mrg_ctl.sum_en = en4;
  assign mrg_ctl.out_en = en_o;

  lmrs_merge u_merge (
    .clk_i  (clk_i),
    .ctl_i  (mrg_ctl),
    .cfg_i  (cfg_q),
    .base_i (base3_q),
    .rise_i (rise3_q),
    .fall_i (fall3_q),
    .pix_o  (pix)
  );

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = pix;
  assign m_axis_tlast  = lasto_q;

  // The input side only stalls when the whole pipeline is full behind a held output beat.
  a_stall_from_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled while the pipeline has room");

  // The last pixel of a frame wraps the counter and swaps the sparkle buffers.
  a_frame_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_render && (pix_cnt_q == PIX_LAST)) |=>
      ((pix_cnt_q == '0) && (buf_sel_q != $past(buf_sel_q)) && prev_ok_q))
    else $error("frame wrap did not swap buffers");

  // The rotation offset only moves at the first pixel of a frame.
  a_rot_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc_render && (pix_cnt_q == '0)) |=> (rot_off_q == $past(rot_off_q)))
    else $error("rotation offset changed mid-frame");

endmodule

@@ rtl/lmrs_merge.sv @@
// Merge stages: adds base colour and both sparkle intensities, then clamps.
// Two register stages, enabled by the pipeline control of the top level.
// Depends on lmrs_pkg.
module lmrs_merge (
  input  logic              clk_i,
  input  lmrs_pkg::mrg_ctl_t ctl_i,
  input  lmrs_pkg::cfg_t    cfg_i,
  input  lmrs_pkg::rgb_t    base_i,
  input  logic [7:0]        rise_i,
  input  logic [7:0]        fall_i,
  output lmrs_pkg::rgb_t    pix_o
);
  import lmrs_pkg::*;

  rgb_sum_t sum_q;
  rgb_t     pix_q;

  function automatic logic [LVL_W-1:0] clamp(input logic [SUM_W-1:0] s_in,
                                             input logic [LVL_W-1:0] lo,
                                             input logic [LVL_W-1:0] hi);
    logic [SUM_W-1:0] s;
    s = s_in;
    if (s < SUM_W'(lo)) s = SUM_W'(lo);
    if (s > SUM_W'(hi)) s = SUM_W'(hi);
    return s[LVL_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      sum_q.red   <= SUM_W'(base_i.red) + SUM_W'(rise_i) + SUM_W'(fall_i);
      sum_q.green <= SUM_W'(base_i.green) + SUM_W'(rise_i) + SUM_W'(fall_i);
      sum_q.blue  <= SUM_W'(base_i.blue) + SUM_W'(rise_i) + SUM_W'(fall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_en) begin
      pix_q.red   <= clamp(sum_q.red, cfg_i.floor_level, cfg_i.peak_level);
      pix_q.green <= clamp(sum_q.green, cfg_i.floor_level, cfg_i.peak_level);
      pix_q.blue  <= clamp(sum_q.blue, cfg_i.floor_level, cfg_i.peak_level);
    end
  end

  assign pix_o = pix_q;

endmodule

@@ tb/led_matrix_rainbow_sparkle_frame_top_test.sv @@
// Self-checking testbench for the LED matrix rainbow sparkle frame renderer.
// A predictor of the base table, the rotation and both sparkle layers checks every pixel beat.
// Depends on lmrs_pkg and led_matrix_rainbow_sparkle_frame_top.
`timescale 1ns / 100ps

module led_matrix_rainbow_sparkle_frame_top_test;
  import lmrs_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 150;

  typedef struct packed {
    func_e func;
    rgb_t  col;
    logic  rise;
    logic  fall;
  } beat_t;

  typedef struct packed {
    logic last;
    rgb_t col;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  led_matrix_rainbow_sparkle_frame_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  cfg_t             cfg;
  rgb_t             base_tbl [PIX_CNT];
  logic [LVL_W-1:0] rise_mem [2][PIX_CNT];
  logic [LVL_W-1:0] fall_mem [2][PIX_CNT];
  logic [PIX_W-1:0] pix_idx;
  logic [PIX_W-1:0] load_ptr;
  logic [PIX_W-1:0] rot_off;
  logic             buf_sel;

  beat_t  pending_beats [$];
  pixel_t due_pixels [$];
  beat_t  cur_beat;
  int     beats_queued = 0;
  int     beats_taken = 0;
  int     renders_seen = 0;
  int     loads_seen = 0;
  int     frames_seen = 0;
  int     settings_cnt = 0;
  int     err_cnt = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     mode_left = 0;
  int     stall_mode = 0;
  int     pat_cnt = 0;
  int     idle_cycles = 0;

  function automatic logic [LVL_W-1:0] decay_or_trigger(logic trig, logic has_src,
                                                         logic [LVL_W-1:0] old);
    if (trig) return cfg.peak_level;
    if (!has_src) return '0;
    return (old > cfg.fade_step) ? old - cfg.fade_step : '0;
  endfunction

  function automatic logic [LVL_W-1:0] merge_level(logic [LVL_W-1:0] base,
                                                   logic [LVL_W-1:0] r,
                                                   logic [LVL_W-1:0] f);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(r) + SUM_W'(f);
    if (s < SUM_W'(cfg.floor_level)) s = SUM_W'(cfg.floor_level);
    if (s > SUM_W'(cfg.peak_level)) s = SUM_W'(cfg.peak_level);
    return s[LVL_W-1:0];
  endfunction

  task automatic shade_beat(input beat_t b);
    logic [PIX_W-1:0] src;
    logic [LVL_W-1:0] r_lvl;
    logic [LVL_W-1:0] f_lvl;
    logic             has_r;
    logic             has_f;
    pixel_t           px;
    if (b.func == FUNC_LOAD) begin
      base_tbl[load_ptr] = b.col;
      load_ptr = load_ptr + 1'b1;
      loads_seen++;
    end else begin
      if (pix_idx == '0) rot_off = rot_off + PIX_W'(cfg.base_shift);
      src = pix_idx - rot_off;
      has_r = (pix_idx >= RISE_STRIDE);
      has_f = (pix_idx >= FALL_STRIDE);
      r_lvl = decay_or_trigger(b.rise, has_r,
                               has_r ? rise_mem[~buf_sel][pix_idx - PIX_W'(RISE_STRIDE)] : '0);
      f_lvl = decay_or_trigger(b.fall, has_f,
                               has_f ? fall_mem[~buf_sel][pix_idx - PIX_W'(FALL_STRIDE)] : '0);
      rise_mem[buf_sel][pix_idx] = r_lvl;
      fall_mem[buf_sel][pix_idx] = f_lvl;
      px.col.red   = merge_level(base_tbl[src].red, r_lvl, f_lvl);
      px.col.green = merge_level(base_tbl[src].green, r_lvl, f_lvl);
      px.col.blue  = merge_level(base_tbl[src].blue, r_lvl, f_lvl);
      px.last      = (pix_idx == PIX_W'(PIX_CNT - 1));
      due_pixels.push_back(px);
      if (px.last) begin
        buf_sel = ~buf_sel;
        frames_seen++;
      end
      pix_idx = pix_idx + 1'b1;
      renders_seen++;
    end
  endtask

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Sender: bursts of random length, with random gaps that are sometimes zero.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        shade_beat(cur_beat);
        beats_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Hold the beat until it is taken.
      end else if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        s_axis_tdata  <= {6'b0, cur_beat.fall, cur_beat.rise, cur_beat.col};
        s_axis_tuser  <= cur_beat.func;
        s_axis_tvalid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall behavior switches among always ready, coin flips and a fixed duty.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_pixels.size() == 0) begin
          note_error($sformatf("unexpected pixel rgb=%h last=%b", m_axis_tdata, m_axis_tlast));
        end else begin
          pixel_t want;
          rgb_t   got;
          want = due_pixels.pop_front();
          got  = m_axis_tdata;
          if (got.red !== want.col.red || got.green !== want.col.green ||
              got.blue !== want.col.blue || m_axis_tlast !== want.last) begin
            note_error($sformatf({"pixel mismatch: expected r=%h g=%h b=%h last=%b, ",
                                  "got r=%h g=%h b=%h last=%b"},
                                 want.col.red, want.col.green, want.col.blue, want.last,
                                 got.red, got.green, got.blue, m_axis_tlast));
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      pat_cnt = (pat_cnt + 1) % 7;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (pat_cnt >= 2);
      endcase
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("led_matrix_rainbow_sparkle_frame_top_test: done, errors");
    $finish;
  end

  function automatic rgb_t rand_rgb();
    return OUT_DATA_W'($urandom);
  endfunction

  function automatic logic [LVL_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return LVL_W'($urandom);
    endcase
  endfunction

  function automatic void queue_beat(func_e f, rgb_t c, logic rise, logic fall);
    beat_t b;
    b.func = f;
    b.col  = c;
    b.rise = rise;
    b.fall = fall;
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  // Waits until every beat is taken and every pixel has come out, then lets loads drain.
  task automatic settle();
    while (beats_taken != beats_queued || due_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    settle();
    write_reg(REG_DECAY, c.fade_step);
    write_reg(REG_PEAK, c.peak_level);
    write_reg(REG_FLOOR, c.floor_level);
    write_reg(REG_SHIFT, c.base_shift);
    cfg = c;
    settings_cnt++;
  endtask

  initial begin
    cfg_t c;
    int   trig_pct;
    cfg.fade_step   = DECAY_RST;
    cfg.peak_level  = PEAK_RST;
    cfg.floor_level = FLOOR_RST;
    cfg.base_shift  = SHIFT_RST;
    pix_idx  = '0;
    load_ptr = '0;
    rot_off  = '0;
    buf_sel  = 1'b0;
    for (int i = 0; i < PIX_CNT; i++) begin
      rise_mem[0][i] = '0;
      rise_mem[1][i] = '0;
      fall_mem[0][i] = '0;
      fall_mem[1][i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the whole table first so that no render reads an unwritten entry.
    queue_beat(FUNC_LOAD, '0, 1'b1, 1'b1);
    queue_beat(FUNC_LOAD, '1, 1'b0, 1'b0);
    for (int i = 2; i < PIX_CNT; i++) queue_beat(FUNC_LOAD, rand_rgb(), 1'b0, 1'b0);

    // Reset settings: every trigger combination, pixels without a predecessor,
    // and a load in the middle of a frame after the load pointer has wrapped.
    queue_beat(FUNC_RENDER, '0, 1'b1, 1'b1);
    queue_beat(FUNC_RENDER, '1, 1'b1, 1'b0);
    queue_beat(FUNC_RENDER, '0, 1'b0, 1'b1);
    queue_beat(FUNC_RENDER, '0, 1'b0, 1'b0);
    queue_beat(FUNC_LOAD, '1, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) begin
      queue_beat(FUNC_RENDER, rand_rgb(), 1'($urandom), 1'($urandom));
    end

    // Floor above a zero peak, no decay, the largest shift.
    c.fade_step   = '0;
    c.peak_level  = '0;
    c.floor_level = '1;
    c.base_shift  = '1;
    apply_settings(c);
    for (int i = 0; i < 8; i++) begin
      queue_beat(FUNC_RENDER, rand_rgb(), 1'($urandom), 1'($urandom));
    end

    // Full decay, full range, no rotation.
    c.fade_step   = '1;
    c.peak_level  = '1;
    c.floor_level = '0;
    c.base_shift  = '0;
    apply_settings(c);
    for (int i = 0; i < 8; i++) begin
      queue_beat(FUNC_RENDER, rand_rgb(), 1'($urandom), 1'($urandom));
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        c.fade_step   = DECAY_RST;
        c.peak_level  = PEAK_RST;
        c.floor_level = FLOOR_RST;
        c.base_shift  = SHIFT_RST;
      end else begin
        c.fade_step   = pick_level();
        c.peak_level  = pick_level();
        c.floor_level = ($urandom_range(0, 2) == 0) ? pick_level() :
                                                      LVL_W'($urandom_range(0, 40));
        c.base_shift  = pick_level();
      end
      apply_settings(c);
      trig_pct = $urandom_range(2, 30);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_beat(FUNC_LOAD, rand_rgb(), 1'($urandom), 1'($urandom));
        end else begin
          queue_beat(FUNC_RENDER, rand_rgb(), $urandom_range(0, 99) < trig_pct,
                     $urandom_range(0, 99) < trig_pct);
        end
      end
    end

    settle();
    $display("Covered %0d render beats and %0d load beats over %0d frames,", renders_seen,
             loads_seen, frames_seen);
    $display("with %0d register settings including the extremes.", settings_cnt);
    if (err_cnt == 0) begin
      $display("led_matrix_rainbow_sparkle_frame_top_test: done, clean");
    end else begin
      $display("%0d mismatches in total.", err_cnt);
      $display("led_matrix_rainbow_sparkle_frame_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ led_matrix_rainbow_sparkle_frame_top.f @@
rtl/lmrs_pkg.sv
rtl/lmrs_merge.sv
rtl/led_matrix_rainbow_sparkle_frame_top.sv
tb/led_matrix_rainbow_sparkle_frame_top_test.sv
